// ===== hdl/irc_tok_pkg.sv =====
package irc_tok_pkg;

    // Highest number of parameters the tokenizer will ever open.
    localparam int unsigned PARAM_LIMIT = 15;

    // Characters that steer the parse.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Tag given to each byte of the message.
    typedef enum logic [2:0] {
        K_SEP    = 3'd0,
        K_PREFIX = 3'd1,
        K_CMD    = 3'd2,
        K_MID    = 3'd3,
        K_TRAIL  = 3'd4,
        K_IGN    = 3'd5
    } field_kind_t;

    // Parse phase, one-hot.
    typedef enum logic [9:0] {
        PH_START       = 10'b00_0000_0001,
        PH_PFX_FIRST   = 10'b00_0000_0010,
        PH_PFX         = 10'b00_0000_0100,
        PH_PFX_GAP     = 10'b00_0000_1000,
        PH_CMD         = 10'b00_0001_0000,
        PH_GAP         = 10'b00_0010_0000,
        PH_MID         = 10'b00_0100_0000,
        PH_TRAIL_FIRST = 10'b00_1000_0000,
        PH_TRAIL       = 10'b01_0000_0000,
        PH_IGNORE      = 10'b10_0000_0000
    } phase_t;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        phase_t     phase;
        logic [3:0] params_seen;
        logic       had_prefix;
    } parse_state_t;

    // Everything reported for one byte, apart from the byte itself.
    typedef struct packed {
        field_kind_t kind;
        logic [3:0]  param_index;
        logic        field_start;
        logic        message_done;
        logic        parse_status;
        logic [3:0]  param_total;
        logic        prefix_present;
    } byte_tag_t;

endpackage

// ===== hdl/irc_tok_classify.sv =====
module irc_tok_classify (
    input  irc_tok_pkg::parse_state_t state_cur,
    input  logic [3:0]                limit,
    input  logic [7:0]                data_byte,
    input  logic                      last_byte,
    output irc_tok_pkg::parse_state_t state_nxt,
    output irc_tok_pkg::byte_tag_t    tag
);
    import irc_tok_pkg::*;

    // Per-byte classification and phase transition.
    always_comb begin
        logic        is_space;
        logic        is_colon;
        logic        room;
        phase_t      ph_next;
        logic [3:0]  seen_next;
        logic        pfx_next;
        field_kind_t kind;
        logic [3:0]  idx;
        logic        start;

        is_space  = (data_byte == CH_SPACE);
        is_colon  = (data_byte == CH_COLON);
        room      = (state_cur.params_seen < limit);
        ph_next   = state_cur.phase;
        seen_next = state_cur.params_seen;
        pfx_next  = state_cur.had_prefix;
        kind      = K_IGN;
        idx       = 4'd0;
        start     = 1'b0;

        case (state_cur.phase)
            PH_START: begin
                if (is_colon) begin
                    pfx_next = 1'b1;
                    kind     = K_SEP;
                    ph_next  = PH_PFX_FIRST;
                end else if (is_space) begin
                    kind    = room ? K_SEP : K_IGN;
                    ph_next = room ? PH_GAP : PH_IGNORE;
                end else begin
                    kind    = K_CMD;
                    start   = 1'b1;
                    ph_next = PH_CMD;
                end
            end
            PH_PFX_FIRST, PH_PFX: begin
                if (is_space) begin
                    kind    = K_SEP;
                    ph_next = PH_PFX_GAP;
                end else begin
                    kind    = K_PREFIX;
                    start   = (state_cur.phase == PH_PFX_FIRST);
                    ph_next = PH_PFX;
                end
            end
            PH_PFX_GAP: begin
                if (is_space) begin
                    kind = K_SEP;
                end else begin
                    kind    = K_CMD;
                    start   = 1'b1;
                    ph_next = PH_CMD;
                end
            end
            PH_CMD: begin
                if (is_space) begin
                    kind    = room ? K_SEP : K_IGN;
                    ph_next = room ? PH_GAP : PH_IGNORE;
                end else begin
                    kind = K_CMD;
                end
            end
            PH_GAP: begin
                if (is_space) begin
                    kind = K_SEP;
                end else if (is_colon) begin
                    seen_next = state_cur.params_seen + 4'd1;
                    kind      = K_SEP;
                    ph_next   = PH_TRAIL_FIRST;
                end else begin
                    seen_next = state_cur.params_seen + 4'd1;
                    kind      = K_MID;
                    idx       = state_cur.params_seen;
                    start     = 1'b1;
                    ph_next   = PH_MID;
                end
            end
            PH_MID: begin
                if (is_space) begin
                    kind    = room ? K_SEP : K_IGN;
                    ph_next = room ? PH_GAP : PH_IGNORE;
                end else begin
                    kind = K_MID;
                    idx  = state_cur.params_seen - 4'd1;
                end
            end
            PH_TRAIL_FIRST, PH_TRAIL: begin
                kind    = K_TRAIL;
                idx     = state_cur.params_seen - 4'd1;
                start   = (state_cur.phase == PH_TRAIL_FIRST);
                ph_next = PH_TRAIL;
            end
            default: begin
                kind    = K_IGN;
                ph_next = PH_IGNORE;
            end
        endcase

        tag.kind           = kind;
        tag.param_index    = idx;
        tag.field_start    = start;
        tag.message_done   = last_byte;
        tag.parse_status   = 1'b0;
        tag.param_total    = 4'd0;
        tag.prefix_present = 1'b0;

        // The final byte reports the summary and rearms the parser.
        if (last_byte) begin
            tag.prefix_present = pfx_next;
            if (ph_next == PH_PFX_FIRST || ph_next == PH_PFX) begin
                tag.parse_status = 1'b1;
            end else if (ph_next == PH_GAP) begin
                tag.param_total = seen_next + 4'd1;
            end else begin
                tag.param_total = seen_next;
            end
            state_nxt.phase       = PH_START;
            state_nxt.params_seen = 4'd0;
            state_nxt.had_prefix  = 1'b0;
        end else begin
            state_nxt.phase       = ph_next;
            state_nxt.params_seen = seen_next;
            state_nxt.had_prefix  = pfx_next;
        end
    end

endmodule

// ===== hdl/irc_message_tokenizer.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_data_byte, s_last_byte
// m_        out        m_valid / m_ready  m_byte_echo .. m_prefix_present
// cfg_      in         cfg_wr_en          cfg_wr_data (max_params)
//
// One byte is taken per clock unless the output stalls; a byte is registered in
// the input stage, then the output stage, which offers its result. The rate is
// set by the parse-state loop. Reset (aresetn low at a clock edge) empties both
// stages, rearms the parser and sets max_params to 15. A stalled output holds
// its result; the input stage keeps taking bytes until both stages are full.
module irc_message_tokenizer (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [3:0]               cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_data_byte,
    input  logic                     s_last_byte,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_byte_echo,
    output irc_tok_pkg::field_kind_t m_field_kind,
    output logic [3:0]               m_param_index,
    output logic                     m_field_start,
    output logic                     m_message_done,
    output logic                     m_parse_status,
    output logic [3:0]               m_param_total,
    output logic                     m_prefix_present
);
    import irc_tok_pkg::*;

    logic [3:0]   max_params_val_reg;
    logic [3:0]   limit;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    logic [7:0]   out_byte_reg;
    byte_tag_t    out_tag_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    byte_tag_t    tag_next;
    logic         advance;

    // Config register; the user writes only while the block is idle, unenforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_params_val_reg <= 4'(PARAM_LIMIT);
        end else if (cfg_wr_en) begin
            max_params_val_reg <= cfg_wr_data;
        end
    end

    // A limit of zero behaves as one.
    assign limit = (max_params_val_reg == 4'd0) ? 4'd1 : max_params_val_reg;

    // The input stage moves on when the output stage is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    irc_tok_classify u_classify (
        .state_cur (state_reg),
        .limit     (limit),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .state_nxt (state_next),
        .tag       (tag_next)
    );

    // Parser state follows each byte as it leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase       <= PH_START;
            state_reg.params_seen <= 4'd0;
            state_reg.had_prefix  <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg <= in_byte_reg;
            out_tag_reg  <= tag_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_byte_echo      = out_byte_reg;
    assign m_field_kind     = out_tag_reg.kind;
    assign m_param_index    = out_tag_reg.param_index;
    assign m_field_start    = out_tag_reg.field_start;
    assign m_message_done   = out_tag_reg.message_done;
    assign m_parse_status   = out_tag_reg.parse_status;
    assign m_param_total    = out_tag_reg.param_total;
    assign m_prefix_present = out_tag_reg.prefix_present;

endmodule

// ===== hdl/irc_tok_checker.sv =====
module irc_tok_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [7:0]               m_byte_echo,
    input irc_tok_pkg::field_kind_t m_field_kind,
    input logic [3:0]               m_param_index,
    input logic                     m_field_start,
    input logic                     m_message_done,
    input logic                     m_parse_status,
    input logic [3:0]               m_param_total,
    input logic                     m_prefix_present
);
    import irc_tok_pkg::*;

    // A stalled result holds still until its transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_echo)
            && $stable(m_field_kind) && $stable(m_message_done))
        else $error("result changed while stalled");

    // Summary fields stay clear except on the final byte.
    a_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_message_done |->
            !m_parse_status && m_param_total == 4'd0 && !m_prefix_present)
        else $error("summary set before the final byte");

    // Only parameter bytes carry a parameter index.
    a_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_field_kind != K_MID && m_field_kind != K_TRAIL
            |-> m_param_index == 4'd0)
        else $error("index on a non-parameter byte");

    // A field start is always a content byte, never a separator or ignored.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_field_start |-> m_field_kind == K_PREFIX
            || m_field_kind == K_CMD || m_field_kind == K_MID
            || m_field_kind == K_TRAIL)
        else $error("field start on a non-content byte");

    // A failed prefix reports no parameters and a prefix.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_parse_status |-> m_param_total == 4'd0 && m_prefix_present)
        else $error("inconsistent error summary");

endmodule

bind irc_message_tokenizer irc_tok_checker u_irc_tok_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_byte_echo      (m_byte_echo),
    .m_field_kind     (m_field_kind),
    .m_param_index    (m_param_index),
    .m_field_start    (m_field_start),
    .m_message_done   (m_message_done),
    .m_parse_status   (m_parse_status),
    .m_param_total    (m_param_total),
    .m_prefix_present (m_prefix_present)
);

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irc_tok_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 200;
    localparam int NUM_PHASES  = 8;

    // Everything the tokenizer reports for one byte.
    typedef struct packed {
        logic [7:0]  byte_echo;
        field_kind_t kind;
        logic [3:0]  param_index;
        logic        field_start;
        logic        message_done;
        logic        parse_status;
        logic [3:0]  param_total;
        logic        prefix_present;
    } tok_result_t;

    // One row of the directed stimulus: a register write or a byte.
    typedef struct {
        bit          is_cfg;
        logic [3:0]  cfg_val;
        logic [7:0]  data;
        bit          last;
        bit          typed;
        tok_result_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = 4'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_byte_echo;
    field_kind_t m_field_kind;
    logic [3:0]  m_param_index;
    logic        m_field_start;
    logic        m_message_done;
    logic        m_parse_status;
    logic [3:0]  m_param_total;
    logic        m_prefix_present;

    // Parser state as the tokenizer should hold it, and its register.
    phase_t      ph_q = PH_START;
    logic [3:0]  seen_q = 4'd0;
    logic        pfx_q = 1'b0;
    logic [3:0]  limit_q = 4'd15;

    tok_result_t pending_tags[$];
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    bit          hold_req = 1'b0;
    int          n_bytes = 0;
    int          n_msgs = 0;
    int          n_ignored = 0;
    int          n_trail = 0;
    int          n_pfx_err = 0;

    irc_message_tokenizer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_echo      (m_byte_echo),
        .m_field_kind     (m_field_kind),
        .m_param_index    (m_param_index),
        .m_field_start    (m_field_start),
        .m_message_done   (m_message_done),
        .m_parse_status   (m_parse_status),
        .m_param_total    (m_param_total),
        .m_prefix_present (m_prefix_present)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A space closes the command or a middle parameter, unless the limit is reached.
    function automatic phase_t close_field(output field_kind_t k);
        logic [3:0] lim;
        lim = (limit_q == 4'd0) ? 4'd1 : limit_q;
        if (lim > PARAM_LIMIT)
            lim = 4'(PARAM_LIMIT);
        if (seen_q < lim) begin
            k = K_SEP;
            return PH_GAP;
        end
        k = K_IGN;
        return PH_IGNORE;
    endfunction

    // Tags one byte and advances the parser state.
    function automatic tok_result_t classify_byte(logic [7:0] b, bit last);
        tok_result_t r;
        phase_t      nxt;
        field_kind_t k;
        r = '0;
        r.byte_echo = b;
        r.message_done = last;
        k = K_IGN;
        nxt = ph_q;
        case (ph_q)
            PH_START: begin
                if (b == CH_COLON) begin
                    pfx_q = 1'b1;
                    k = K_SEP;
                    nxt = PH_PFX_FIRST;
                end else if (b == CH_SPACE) begin
                    nxt = close_field(k);
                end else begin
                    k = K_CMD;
                    r.field_start = 1'b1;
                    nxt = PH_CMD;
                end
            end
            PH_PFX_FIRST, PH_PFX: begin
                if (b == CH_SPACE) begin
                    k = K_SEP;
                    nxt = PH_PFX_GAP;
                end else begin
                    k = K_PREFIX;
                    r.field_start = (ph_q == PH_PFX_FIRST);
                    nxt = PH_PFX;
                end
            end
            PH_PFX_GAP: begin
                if (b == CH_SPACE) begin
                    k = K_SEP;
                end else begin
                    k = K_CMD;
                    r.field_start = 1'b1;
                    nxt = PH_CMD;
                end
            end
            PH_CMD: begin
                if (b == CH_SPACE)
                    nxt = close_field(k);
                else
                    k = K_CMD;
            end
            PH_GAP: begin
                if (b == CH_SPACE) begin
                    k = K_SEP;
                end else if (b == CH_COLON) begin
                    seen_q = seen_q + 4'd1;
                    k = K_SEP;
                    nxt = PH_TRAIL_FIRST;
                end else begin
                    seen_q = seen_q + 4'd1;
                    k = K_MID;
                    r.param_index = seen_q - 4'd1;
                    r.field_start = 1'b1;
                    nxt = PH_MID;
                end
            end
            PH_MID: begin
                if (b == CH_SPACE) begin
                    nxt = close_field(k);
                end else begin
                    k = K_MID;
                    r.param_index = seen_q - 4'd1;
                end
            end
            PH_TRAIL_FIRST, PH_TRAIL: begin
                k = K_TRAIL;
                r.param_index = seen_q - 4'd1;
                r.field_start = (ph_q == PH_TRAIL_FIRST);
                nxt = PH_TRAIL;
            end
            default: begin
                k = K_IGN;
                nxt = PH_IGNORE;
            end
        endcase
        r.kind = k;
        // The final byte reports the summary and rearms the parser.
        if (last) begin
            r.prefix_present = pfx_q;
            if (nxt == PH_PFX_FIRST || nxt == PH_PFX)
                r.parse_status = 1'b1;
            else if (nxt == PH_GAP)
                r.param_total = seen_q + 4'd1;
            else
                r.param_total = seen_q;
            ph_q = PH_START;
            seen_q = 4'd0;
            pfx_q = 1'b0;
        end else begin
            ph_q = nxt;
        end
        return r;
    endfunction

    function automatic tok_result_t mk_res(logic [7:0] b, field_kind_t k, logic [3:0] idx,
                                           bit st, bit dn, bit ps, logic [3:0] tot, bit pf);
        tok_result_t r;
        r = '{b, k, idx, st, dn, ps, tot, pf};
        return r;
    endfunction

    function automatic dir_row_t byte_row(logic [7:0] d, bit l);
        dir_row_t row;
        row = '{1'b0, 4'd0, d, l, 1'b0, '0};
        return row;
    endfunction

    function automatic dir_row_t typed_row(tok_result_t w);
        dir_row_t row;
        row = '{1'b0, 4'd0, w.byte_echo, w.message_done, 1'b1, w};
        return row;
    endfunction

    function automatic dir_row_t cfg_row(logic [3:0] v);
        dir_row_t row;
        row = '{1'b1, v, 8'd0, 1'b0, 1'b0, '0};
        return row;
    endfunction

    // A message byte: anything but a space, and a colon only where allowed.
    function automatic logic [7:0] text_byte(bit colon_ok);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || (!colon_ok && b == CH_COLON));
        return b;
    endfunction

    // Offers one byte and waits for its transfer; the expectation is queued first.
    task automatic send_byte(logic [7:0] b, bit l, bit gaps, tok_result_t want);
        int g;
        g = gaps ? pick_gap() : 0;
        pending_tags.push_back(want);
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= l;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Register write once the tokenizer has drained.
    task automatic set_limit(logic [3:0] v);
        s_valid <= 1'b0;
        while (pending_tags.size() != 0)
            @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        limit_q = v;
    endtask

    // Builds one message: mostly well formed, with random content, some noise.
    task automatic compose_message(ref logic [7:0] m[$]);
        int n;
        int np;
        int r;
        m.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                r = $urandom_range(0, 3);
                m.push_back(r == 0 ? CH_COLON : r == 1 ? CH_SPACE : 8'($urandom_range(0, 255)));
            end
            return;
        end
        // Optional prefix, occasionally cut off before its space.
        if ($urandom_range(0, 1) == 1) begin
            m.push_back(CH_COLON);
            n = $urandom_range(0, 6);
            repeat (n) m.push_back(text_byte(1'b1));
            if ($urandom_range(0, 9) == 0)
                return;
            repeat ($urandom_range(1, 2)) m.push_back(CH_SPACE);
        end
        // Command, empty now and then.
        if ($urandom_range(0, 9) != 0) begin
            m.push_back(text_byte(1'b0));
            repeat ($urandom_range(0, 4)) m.push_back(text_byte(1'b1));
        end
        // Parameters; a few messages run past the largest limit.
        np = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 17) : $urandom_range(0, 5);
        for (int i = 0; i < np; i++) begin
            repeat ($urandom_range(1, 2)) m.push_back(CH_SPACE);
            if (i == np - 1 && $urandom_range(0, 2) == 0) begin
                m.push_back(CH_COLON);
                repeat ($urandom_range(0, 8))
                    m.push_back(($urandom_range(0, 3) == 0) ? CH_SPACE : text_byte(1'b1));
            end else begin
                m.push_back(text_byte(1'b0));
                repeat ($urandom_range(0, 3)) m.push_back(text_byte(1'b1));
            end
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) m.push_back(CH_SPACE);
        if (m.size() == 0)
            m.push_back(CH_SPACE);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // Result side: random stalls in stretches, calm stretches, and one long hold-off.
    initial begin
        int  stall;
        int  hold;
        int  mode_left;
        int  g;
        bit  gappy;
        bit  hold_taken;
        stall = 0;
        hold = 0;
        mode_left = 0;
        gappy = 1'b1;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (mode_left == 0) begin
                gappy = ($urandom_range(0, 2) != 0);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (gappy) begin
                g = pick_gap();
                if (g > 0)
                    stall = g - 1;
                m_ready <= (g == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Each result transfer is checked against the oldest expectation.
    always @(posedge aclk) begin
        tok_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tags.size() == 0) begin
                $error("unexpected result: byte %0d with nothing outstanding", m_byte_echo);
                fail_cnt++;
            end else begin
                want = pending_tags.pop_front();
                check_field("byte_echo", want.byte_echo, m_byte_echo);
                check_field("field_kind", want.kind, m_field_kind);
                check_field("param_index", want.param_index, m_param_index);
                check_field("field_start", want.field_start, m_field_start);
                check_field("message_done", want.message_done, m_message_done);
                check_field("parse_status", want.parse_status, m_parse_status);
                check_field("param_total", want.param_total, m_param_total);
                check_field("prefix_present", want.prefix_present, m_prefix_present);
                n_bytes++;
                n_msgs += want.message_done;
                n_pfx_err += want.parse_status;
                if (want.kind == K_IGN)
                    n_ignored++;
                if (want.kind == K_TRAIL)
                    n_trail++;
            end
        end
    end

    // Input side: reset, directed table, then random phases over several limits.
    initial begin
        dir_row_t    dir_tab[$];
        dir_row_t    row;
        logic [7:0]  msg[$];
        tok_result_t want;
        int          phase_bytes;
        bit          calm;
        logic [3:0]  lim;

        // Prefix, command, middle and trailing parameters, byte extremes.
        dir_tab.push_back(typed_row(mk_res(CH_COLON, K_SEP, 4'd0, 0, 0, 0, 4'd0, 0)));
        dir_tab.push_back(byte_row("n", 1'b0));
        dir_tab.push_back(byte_row(CH_SPACE, 1'b0));
        dir_tab.push_back(byte_row("P", 1'b0));
        dir_tab.push_back(byte_row(CH_SPACE, 1'b0));
        dir_tab.push_back(byte_row("x", 1'b0));
        dir_tab.push_back(byte_row(CH_SPACE, 1'b0));
        dir_tab.push_back(byte_row(CH_COLON, 1'b0));
        dir_tab.push_back(byte_row(CH_SPACE, 1'b0));
        dir_tab.push_back(typed_row(mk_res(8'hFF, K_TRAIL, 4'd1, 0, 1, 0, 4'd2, 1)));
        // Prefix with no space after it.
        dir_tab.push_back(byte_row(CH_COLON, 1'b0));
        dir_tab.push_back(typed_row(mk_res(8'h00, K_PREFIX, 4'd0, 1, 1, 1, 4'd0, 1)));
        // A lone space: empty command plus one empty parameter.
        dir_tab.push_back(typed_row(mk_res(CH_SPACE, K_SEP, 4'd0, 0, 1, 0, 4'd1, 0)));
        // Trailing space after the command.
        dir_tab.push_back(byte_row("A", 1'b0));
        dir_tab.push_back(byte_row(CH_SPACE, 1'b1));
        // Single-byte message.
        dir_tab.push_back(typed_row(mk_res(8'hFF, K_CMD, 4'd0, 1, 1, 0, 4'd0, 0)));
        // Limit of zero behaves as one: the second parameter is ignored.
        dir_tab.push_back(cfg_row(4'd0));
        dir_tab.push_back(byte_row("C", 1'b0));
        dir_tab.push_back(byte_row(CH_SPACE, 1'b0));
        dir_tab.push_back(byte_row("x", 1'b0));
        dir_tab.push_back(byte_row(CH_SPACE, 1'b0));
        dir_tab.push_back(typed_row(mk_res("y", K_IGN, 4'd0, 0, 1, 0, 4'd1, 0)));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.is_cfg) begin
                set_limit(row.cfg_val);
            end else begin
                want = classify_byte(row.data, row.last);
                if (row.typed)
                    want = row.want;
                send_byte(row.data, row.last, 1'b1, want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: lim = 4'd15;
                1: lim = 4'd1;
                2: lim = 4'd0;
                default: lim = 4'($urandom_range(0, 15));
            endcase
            set_limit(lim);
            // One long hold-off on the result side while bytes keep coming.
            if (p == 2)
                hold_req = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                compose_message(msg);
                calm = ($urandom_range(0, 3) == 0);
                foreach (msg[j]) begin
                    want = classify_byte(msg[j], j == msg.size() - 1);
                    send_byte(msg[j], j == msg.size() - 1, !calm, want);
                end
                phase_bytes += msg.size();
            end
        end

        s_valid <= 1'b0;
        while (pending_tags.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Tokenised %0d bytes in %0d messages with the parameter limit swept 0 to 15.",
                 n_bytes, n_msgs);
        $display("Seen: %0d ignored bytes, %0d trailing bytes, %0d unterminated prefixes.",
                 n_ignored, n_trail, n_pfx_err);
        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/irc_tok_pkg.sv
hdl/irc_tok_classify.sv
hdl/irc_message_tokenizer.sv
hdl/irc_tok_checker.sv
verif/tb.sv
